### rtl/lrfp_pkg.sv
// Shared types and constants for the range sensor frame parser.
// No dependencies; imported by lrfp_step and lidar_range_frame_parser_top.
package lrfp_pkg;

  localparam logic [7:0]  HEADER_BYTE       = 8'h5C;
  localparam logic [15:0] OUT_OF_RANGE_CODE = 16'd50000;
  localparam logic [15:0] INVALID_DISTANCE  = 16'hFFFF;
  localparam logic [15:0] DEFAULT_TIMEOUT   = 16'd2000;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_OFFSET  = 1'b0,
    REG_TIMEOUT = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    POS_IDLE = 2'd0,
    POS_LOW  = 2'd1,
    POS_HIGH = 2'd2,
    POS_SUM  = 2'd3
  } byte_pos_t;

  typedef struct packed {
    logic        in_frame;
    byte_pos_t   byte_position;
    logic [7:0]  low_byte;
    logic [7:0]  high_byte;
    logic [15:0] distance;
    logic [15:0] ticks_since_fresh;
  } parser_state_t;

  typedef struct packed {
    logic [15:0] distance_mm;
    logic        frame_done;
    logic        fresh_reading;
    logic        checksum_error;
  } parser_result_t;

endpackage

### rtl/lrfp_step.sv
// Next-state and result logic for one parser transfer (byte or tick).
// Depends on lrfp_pkg.
module lrfp_step (
  input  logic                   opcode,
  input  logic [7:0]             rx_byte,
  input  logic signed [15:0]     offset_mm,
  input  logic [15:0]            timeout_ticks,
  input  lrfp_pkg::parser_state_t  cur,
  output lrfp_pkg::parser_state_t  nxt,
  output lrfp_pkg::parser_result_t res
);
  import lrfp_pkg::*;

  logic [15:0] raw;
  logic [7:0]  expect_sum;
  logic [17:0] corr;
  logic [15:0] clamped;

  assign raw        = {cur.high_byte, cur.low_byte};
  assign expect_sum = ~(cur.low_byte + cur.high_byte);
  assign corr       = $signed({2'b00, raw}) + $signed({{2{offset_mm[15]}}, offset_mm});

  always_comb begin
    if (corr[17]) begin
      clamped = 16'd0;
    end else if (corr[16]) begin
      clamped = INVALID_DISTANCE;
    end else begin
      clamped = corr[15:0];
    end
  end

  always_comb begin
    nxt                = cur;
    res.frame_done     = 1'b0;
    res.fresh_reading  = 1'b0;
    res.checksum_error = 1'b0;
    if (opcode_t'(opcode) == OP_TICK) begin
      if (cur.ticks_since_fresh != 16'hFFFF) begin
        nxt.ticks_since_fresh = cur.ticks_since_fresh + 16'd1;
      end
    end else if (!cur.in_frame) begin
      if (rx_byte == HEADER_BYTE) begin
        nxt.in_frame      = 1'b1;
        nxt.byte_position = POS_LOW;
      end
    end else begin
      unique case (cur.byte_position)
        POS_IDLE, POS_LOW: begin
          nxt.low_byte      = rx_byte;
          nxt.byte_position = POS_HIGH;
        end
        POS_HIGH: begin
          nxt.high_byte     = rx_byte;
          nxt.byte_position = POS_SUM;
        end
        POS_SUM: begin
          nxt.in_frame      = 1'b0;
          nxt.byte_position = POS_IDLE;
          if (expect_sum == rx_byte) begin
            res.frame_done = 1'b1;
            if (raw == OUT_OF_RANGE_CODE) begin
              nxt.distance = INVALID_DISTANCE;
            end else begin
              nxt.distance          = clamped;
              nxt.ticks_since_fresh = 16'd0;
              res.fresh_reading     = 1'b1;
            end
          end else begin
            res.checksum_error = 1'b1;
          end
        end
        default: begin
          nxt.byte_position = POS_HIGH;
        end
      endcase
    end
    if (nxt.ticks_since_fresh > timeout_ticks) begin
      nxt.distance = INVALID_DISTANCE;
    end
    res.distance_mm = nxt.distance;
  end

endmodule

### rtl/lidar_range_frame_parser_top.sv
// Range sensor serial frame parser with freshness timeout: top level.
// Depends on lrfp_pkg and lrfp_step.
//
// Each transfer is a serial byte or a millisecond tick and yields exactly one
// result: the current distance and the frame flags. A transfer passes through
// the input register, then the result register; one transfer is accepted
// every cycle while the result side keeps up, set by the state update between
// the two registers. Configuration writes take effect at once and
// should be made while no transfer is in flight.
module lidar_range_frame_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] distance_mm,
  output logic        frame_done,
  output logic        fresh_reading,
  output logic        checksum_error
);
  import lrfp_pkg::*;

  logic signed [15:0] offset_mm;
  logic [15:0]        timeout_ticks;
  logic               s1_valid;
  logic               s1_opcode;
  logic [7:0]         s1_byte;
  logic               advance;
  parser_state_t      st;
  parser_state_t      st_next;
  parser_result_t     res;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_mm     <= '0;
      timeout_ticks <= DEFAULT_TIMEOUT;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_OFFSET:  offset_mm     <= cfg_wdata;
        REG_TIMEOUT: timeout_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_opcode <= opcode;
      s1_byte   <= rx_byte;
    end
  end

  lrfp_step u_step (
    .opcode        (s1_opcode),
    .rx_byte       (s1_byte),
    .offset_mm     (offset_mm),
    .timeout_ticks (timeout_ticks),
    .cur           (st),
    .nxt           (st_next),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.in_frame          <= 1'b0;
      st.byte_position     <= POS_IDLE;
      st.low_byte          <= '0;
      st.high_byte         <= '0;
      st.distance          <= INVALID_DISTANCE;
      st.ticks_since_fresh <= '0;
    end else if (s1_valid && advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
    if (s1_valid && advance) begin
      distance_mm    <= res.distance_mm;
      frame_done     <= res.frame_done;
      fresh_reading  <= res.fresh_reading;
      checksum_error <= res.checksum_error;
    end
  end

`ifndef SYNTH
  a_fresh_is_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && fresh_reading |-> frame_done)
    else $error("fresh reading without completed frame");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(frame_done && checksum_error))
    else $error("frame both good and bad");

  a_idle_position: assert property (@(posedge clk) disable iff (rst)
    !st.in_frame |-> st.byte_position == POS_IDLE)
    else $error("byte position set outside a frame");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule
